>>> sv/fvn_pkg.sv
// shared types and constants of the feature vector normalizer
`timescale 1ns / 1ps
package fvn_pkg;

   localparam int MAX_LENGTH_DEF = 64;

   localparam int BIN_W  = 16;
   localparam int GAIN_W = 16;
   localparam int OUT_W  = 32;
   localparam int ACC_W  = 38;
   localparam int NUM_W  = 56;
   localparam int REM_W  = 39;
   localparam int ROOT_W = 28;
   localparam int STEP_W = 6;
   localparam int MUL_A_W = ROOT_W;
   localparam int PROD_W  = MUL_A_W + GAIN_W;

   localparam int DIV_STEPS  = NUM_W;
   localparam int SQRT_STEPS = NUM_W / 2;

   typedef enum logic [1:0] {
      MODE_L1      = 2'd0,
      MODE_L1_SQRT = 2'd1,
      MODE_L2      = 2'd2,
      MODE_PASS    = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_NORM_MODE = 1'b0,
      CSR_MAGNIFY   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_SQRT_NORM,
      ST_EL_RD,
      ST_EL_LOAD,
      ST_DIV,
      ST_SQRT_EL,
      ST_MUL_GAIN,
      ST_EMIT
   } state_type;

endpackage

>>> sv/feature_vector_normalizer.sv
// top level of the feature vector normalizer: sequencer and shared divide/root unit
`timescale 1ns / 1ps
// usage
// - input items (req_bin_value, req_last_bin) are taken on a rising edge with start high
//   and busy low; each item is one element of the vector
// - an element not marked last (and not filling the store) is only stored and busy
//   stays low
// - the last element (or the one that fills MAX_LENGTH entries) starts processing and
//   busy stays high until the last result item is loaded; that item shows on the
//   result ports in the first cycle with busy low again
// - processing: a sum pass that reads and accumulates each element, then for L2 a root
//   of the sum of squares; then per element a divide for L1 and L2 (one restoring divide
//   step per cycle over 56 quotient bits), for L1-sqrt a divide, then 28 root steps
//   and a gain multiply, and neither for pass-through or a zero norm
// - the divide/root register set is shared, so elements are processed one at a time
// - results appear on rsp_norm_value / rsp_last_out for one cycle with rsp_valid;
//   the receiver cannot stall, so nothing waits on it
// - csr writes (csr_we, csr_index, csr_wdata) are taken at once and are meant for
//   idle time only
// - reset returns the sequencer to idle, clears the element count and sets the mode to
//   pass-through with gain 1; the element store keeps its contents
module feature_vector_normalizer
   import fvn_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [BIN_W-1:0]     req_bin_value,
   input  logic                 req_last_bin,
   output logic                 rsp_valid,
   output logic [OUT_W-1:0]     rsp_norm_value,
   output logic                 rsp_last_out,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int CW = $clog2(MAX_LENGTH + 1);

   // element store, registered read
   logic [BIN_W-1:0] mem [MAX_LENGTH];
   logic [BIN_W-1:0] rd_data_ff;

   // control
   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   mode_type         mode_ff, mode_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // shared divide / root unit
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ROOT_W-1:0] l2n_ff, l2n_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ACC_W-1:0]  den_ff, den_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              final_elem;
   logic              last_idx;
   logic              zero_norm;
   logic [MUL_A_W-1:0] mul_a;
   logic [PROD_W-1:0] prod;
   logic [REM_W-1:0]  div_rem;
   logic              div_ge;
   logic [REM_W-1:0]  sq_rem;
   logic [REM_W-1:0]  sq_trial;
   logic              sq_ge;
   logic [ACC_W-1:0]  sum_term;

   assign accept     = start && !busy;
   assign final_elem = req_last_bin || (cnt_ff == CW'(MAX_LENGTH - 1));
   assign last_idx   = ((CW'(idx_ff) + CW'(1)) == n_ff);
   assign zero_norm  = (mode_ff == MODE_L2) ? (l2n_ff == '0) : (acc_ff == '0);

   // one multiplier: bin times gain, or root times gain
   assign mul_a = (state_ff == ST_MUL_GAIN) ? root_ff : MUL_A_W'(rd_data_ff);
   assign prod  = mul_a * gain_ff;

   // sum term: bin, or bin squared for L2
   always_comb begin
      if (mode_ff == MODE_L2) begin
         sum_term = ACC_W'(rd_data_ff * rd_data_ff);
      end else begin
         sum_term = ACC_W'(rd_data_ff);
      end
   end

   // restoring divide step
   assign div_rem = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign div_ge  = (div_rem >= REM_W'(den_ff));

   // digit-by-digit root step, two radicand bits a step
   assign sq_rem   = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
   assign sq_trial = REM_W'({root_ff, 2'b01});
   assign sq_ge    = (sq_rem >= sq_trial);

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_value = rsp_value_ff;
   assign rsp_last_out   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[cnt_ff[AW-1:0]] <= req_bin_value;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      acc_in       = acc_ff;
      l2n_in       = l2n_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      den_in       = den_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORM_MODE: mode_in = mode_type'(csr_wdata[1:0]);
            CSR_MAGNIFY:   gain_in = csr_wdata;
            default:       gain_in = gain_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (final_elem) begin
                  n_in     = cnt_ff + CW'(1);
                  cnt_in   = '0;
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = ST_SUM_RD;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            acc_in = acc_ff + sum_term;
            if (last_idx) begin
               idx_in = '0;
               if (mode_ff == MODE_L2) begin
                  num_in   = NUM_W'({acc_in, 16'b0});
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = '0;
                  state_in = ST_SQRT_NORM;
               end else begin
                  state_in = ST_EL_RD;
               end
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SUM_RD;
            end
         end
         ST_SQRT_NORM, ST_SQRT_EL: begin
            num_in = {num_ff[NUM_W-3:0], 2'b00};
            if (sq_ge) begin
               rem_in  = sq_rem - sq_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               if (state_ff == ST_SQRT_NORM) begin
                  l2n_in   = root_in;
                  state_in = ST_EL_RD;
               end else begin
                  state_in = ST_MUL_GAIN;
               end
            end
         end
         ST_EL_RD: begin
            state_in = ST_EL_LOAD;
         end
         ST_EL_LOAD: begin
            rem_in  = '0;
            root_in = '0;
            step_in = '0;
            if (mode_ff == MODE_PASS) begin
               rsp_value_in = {rd_data_ff, 16'b0};
               state_in     = ST_EMIT;
            end else if (zero_norm) begin
               rsp_value_in = '0;
               state_in     = ST_EMIT;
            end else begin
               unique case (mode_ff)
                  MODE_L1: begin
                     num_in = NUM_W'({prod[OUT_W-1:0], 16'b0});
                     den_in = acc_ff;
                  end
                  MODE_L1_SQRT: begin
                     num_in = NUM_W'({rd_data_ff, 32'b0});
                     den_in = acc_ff;
                  end
                  default: begin
                     num_in = {prod[OUT_W-1:0], 24'b0};
                     den_in = ACC_W'(l2n_ff);
                  end
               endcase
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_in = div_rem - REM_W'(den_ff);
            end else begin
               rem_in = div_rem;
            end
            num_in  = {num_ff[NUM_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               if (mode_ff == MODE_L1_SQRT) begin
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_SQRT_EL;
               end else begin
                  rsp_value_in = (num_in[NUM_W-1:OUT_W] != '0) ? '1 : num_in[OUT_W-1:0];
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_MUL_GAIN: begin
            rsp_value_in = (prod[PROD_W-1:OUT_W] != '0) ? '1 : prod[OUT_W-1:0];
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = last_idx;
            if (last_idx) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_EL_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         mode_ff      <= MODE_PASS;
         gain_ff      <= GAIN_W'(1);
         acc_ff       <= '0;
         l2n_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         acc_ff       <= acc_in;
         l2n_ff       <= l2n_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      den_ff       <= den_in;
      rsp_value_ff <= rsp_value_in;
   end

   // a result leaves only right after the emit state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result strobe without emit");

   // results are never back to back
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe in consecutive cycles");

   // a final element always starts processing
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && final_elem) |=> busy)
      else $error("final element did not start processing");

   // element count stays below the store depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CW'(MAX_LENGTH))
      else $error("element count out of range");

endmodule

>>> tb/tb_feature_vector_normalizer.sv
// self-checking testbench of the feature vector normalizer
`timescale 1ns / 1ps
module tb_feature_vector_normalizer
   import fvn_pkg::*;
;

   localparam int VEC_MAX     = MAX_LENGTH_DEF;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_WAIT  = 200;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [BIN_W-1:0]  req_bin_value = '0;
   logic              req_last_bin = 1'b0;
   logic              rsp_valid;
   logic [OUT_W-1:0]  rsp_norm_value;
   logic              rsp_last_out;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   feature_vector_normalizer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_bin_value(req_bin_value), .req_last_bin(req_last_bin),
      .rsp_valid(rsp_valid), .rsp_norm_value(rsp_norm_value),
      .rsp_last_out(rsp_last_out), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: a private copy of the block's registers
   mode_type          cur_mode;
   logic [GAIN_W-1:0] cur_gain;
   logic [BIN_W-1:0]  held_bins[VEC_MAX];
   int                held_count;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
   } norm_result_type;

   norm_result_type pending_results[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              idle_pct = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic [OUT_W-1:0] clip32(logic [127:0] v);
      return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // normalize the held vector and queue one result per element
   task automatic emit_normalized_vector();
      logic [127:0] norm_sum;
      logic [127:0] l2_root;
      logic [127:0] e;
      logic [127:0] r;
      norm_result_type item;
      norm_sum = 0;
      for (int i = 0; i < held_count; i++) begin
         e = held_bins[i];
         norm_sum += (cur_mode == MODE_L2) ? e * e : e;
      end
      norm_sum &= (128'd1 << ACC_W) - 1;
      l2_root = int_sqrt(64'(norm_sum << 16));
      for (int i = 0; i < held_count; i++) begin
         e = held_bins[i];
         case (cur_mode)
            MODE_L1: r = (norm_sum == 0) ? 0 : ((e * cur_gain) << 16) / norm_sum;
            MODE_L1_SQRT: r = (norm_sum == 0) ? 0
                              : cur_gain * int_sqrt(64'((e << 32) / norm_sum));
            MODE_L2: r = (l2_root == 0) ? 0 : ((e * cur_gain) << 24) / l2_root;
            default: r = e << 16;
         endcase
         item.value = clip32(r);
         item.last  = (i + 1 == held_count);
         pending_results.insert(pending_results.size(), item);
      end
      held_count = 0;
   endtask

   task automatic predict_bin(logic [BIN_W-1:0] bin, logic last);
      held_bins[held_count] = bin;
      held_count++;
      if (last || held_count >= VEC_MAX) emit_normalized_vector();
   endtask

   // result checker: the receiver never stalls, so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result value=%h last=%b", rsp_norm_value, rsp_last_out);
         end else begin
            norm_result_type want;
            want = pending_results.pop_front();
            if (rsp_norm_value !== want.value || rsp_last_out !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value=%h last=%b, got value=%h last=%b",
                           want.value, want.last, rsp_norm_value, rsp_last_out);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one write, then the write strobe is dropped before the task returns
   task automatic write_csr(csr_index_type idx, logic [GAIN_W-1:0] data);
      start     <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NORM_MODE) cur_mode = mode_type'(data[1:0]);
      else cur_gain = data;
      @(posedge clock);
   endtask

   task automatic set_config(mode_type mode, logic [GAIN_W-1:0] gain);
      write_csr(CSR_NORM_MODE, GAIN_W'(mode));
      write_csr(CSR_MAGNIFY, gain);
   endtask

   // sender holds off until every result has come, then idles before returning
   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // present one item and hold it until accepted; start stays high back to back
   task automatic send_bin(logic [BIN_W-1:0] bin, logic last);
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_bin_value <= bin;
      req_last_bin  <= last;
      do @(posedge clock); while (busy);
      predict_bin(bin, last);
   endtask

   typedef struct {
      logic [BIN_W-1:0] bin;
      logic             last;
      logic             known;
      logic [OUT_W-1:0] value;
   } stim_row_type;

   // directed rows in pass-through after reset: results read off directly
   stim_row_type pass_rows[] = '{
      '{16'h0000, 1'b1, 1'b1, 32'h0000_0000},
      '{16'hFFFF, 1'b1, 1'b1, 32'hFFFF_0000},
      '{16'h0001, 1'b0, 1'b0, 32'h0},
      '{16'h8000, 1'b1, 1'b1, 32'h8000_0000}
   };

   // zero vector under a normalizing mode gives zero outputs
   stim_row_type zero_rows[] = '{
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b1, 1'b1, 32'h0000_0000}
   };

   task automatic run_rows(stim_row_type rows[]);
      foreach (rows[i]) begin
         send_bin(rows[i].bin, rows[i].last);
         if (rows[i].known && rows[i].last &&
             pending_results[pending_results.size() - 1].value !== rows[i].value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("row %0d: expected value=%h, predicted value=%h", i,
                        rows[i].value, pending_results[pending_results.size() - 1].value);
         end
      end
   endtask

   task automatic random_vector(int max_len);
      int len;
      logic [BIN_W-1:0] bin;
      len = ($urandom_range(19, 0) == 0) ? VEC_MAX : $urandom_range(max_len, 1);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5, 0))
            0: bin = 16'hFFFF;
            1: bin = '0;
            2: bin = 16'($urandom_range(15, 0));
            default: bin = 16'($urandom());
         endcase
         // full length ends itself; mark it last only sometimes
         send_bin(bin, (i == len - 1) && (len < VEC_MAX || $urandom_range(1, 0)));
      end
   endtask

   initial begin
      mode_type modes[4];
      modes = '{MODE_L1, MODE_L1_SQRT, MODE_L2, MODE_PASS};
      cur_mode   = MODE_PASS;
      cur_gain   = 1;
      held_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, extremes, zero norm, full store, every mode
      run_rows(pass_rows);
      drain();
      set_config(MODE_L1, 16'hFFFF);
      run_rows(zero_rows);
      send_bin(16'hFFFF, 1'b1);   // largest bin with the largest gain
      drain();
      set_config(MODE_L2, 16'd0);  // zero gain
      send_bin(16'h1234, 1'b0);
      send_bin(16'hFFFF, 1'b1);
      drain();
      set_config(MODE_L1_SQRT, 16'd1);
      send_bin(16'h0001, 1'b0);
      send_bin(16'hFFFF, 1'b1);
      drain();
      set_config(MODE_L2, 16'd1);
      for (int i = 0; i < VEC_MAX; i++) send_bin(16'(i * 1000), 1'b0);  // fills store
      drain();
      // mode change mid-vector: only the final mode matters
      send_bin(16'h00FF, 1'b0);
      write_csr(CSR_NORM_MODE, GAIN_W'(MODE_L1));
      send_bin(16'h0F00, 1'b1);
      drain();

      // random phases with different idle levels and settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 54;
            2: idle_pct = 54;
            default: idle_pct = 23;
         endcase
         set_config(modes[phase % 4],
                    (phase == 3) ? 16'hFFFF : (phase == 5) ? 16'd1
                    : 16'($urandom_range(65535, 1)));
         for (int v = 0; v < 2; v++) random_vector(10);
         drain();
      end

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
